// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared constants and types for the Jacobi symbol unit: operand width,
// result codes and the control and status groups of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Width of the ports for a and n, fixed by the interface.
  localparam int unsigned FIELD_W = 64;
  // Working width of the datapath; only the low WIDTH bits of each operand
  // take part. Legal range 8 to 64.
  localparam int unsigned WIDTH   = 64;
  localparam int unsigned SYM_W   = 2;
  localparam int unsigned ST_W    = 2;

  localparam logic signed [SYM_W-1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [SYM_W-1:0] SYM_POS  = 2'sb01;
  localparam logic signed [SYM_W-1:0] SYM_NEG  = 2'sb11;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EVEN      = 2'd1,
    ST_NOT_BELOW = 2'd2,
    ST_SMALL     = 2'd3
  } status_t;

  // Operation the datapath applies to the a and n registers.
  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD,
    DP_SHIFT,
    DP_SWAP,
    DP_SUB
  } dp_op_t;

  // Condition flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic       a_zero;
    logic       a_lt_n;
    logic       n_is_one;
    logic [1:0] a_low;
    logic [2:0] n_low;
  } dp_stat_t;

endpackage : jsu_pkg

`default_nettype wire

// ===== rtl/jacobi_symbol_unit.sv =====
// ----------------------------------------------------------------------------
// jacobi_symbol_unit
// Jacobi symbol (a/n) by the binary subtract-and-shift method, one step of
// the shared subtractor per cycle under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready   | in_a_value, in_n_modulus
//  out     | output    | out_valid / out_ready | out_symbol, out_status
//
// One transaction occupies the unit from acceptance to result: the operands
// are loaded, checked, then reduced by halving, swap or subtraction until a
// is zero; a rejected operand pair goes from the check straight to the result.
// The loop does one step a cycle, around a single shared subtractor.
// in_ready is high only while idle. A finished result waits in the sequencer
// until the output register is free, so out_ready may stall freely.
// Reset (rst_n low, synchronous) returns the unit to idle with no result.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_symbol_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [jsu_pkg::FIELD_W-1:0]        in_a_value,
  input  wire logic [jsu_pkg::FIELD_W-1:0]        in_n_modulus,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [jsu_pkg::SYM_W-1:0]        out_symbol,
  output logic [jsu_pkg::ST_W-1:0]                out_status
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [SYM_W-1:0] res_sym_r, res_sym_nxt;
  status_t                 res_st_r, res_st_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  status_t                 out_status_r, out_status_nxt;
  dp_op_t                  op;
  dp_stat_t                stat;

  jsu_datapath u_dp (
    .clk      (clk),
    .op_i     (op),
    .load_a_i (in_a_value[WIDTH-1:0]),
    .load_n_i (in_n_modulus[WIDTH-1:0]),
    .stat_o   (stat)
  );

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    res_sym_nxt    = res_sym_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_symbol_nxt = out_symbol_r;
    out_status_nxt = out_status_r;
    op             = DP_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        neg_nxt     = 1'b0;
        res_sym_nxt = SYM_ZERO;
        res_st_nxt  = ST_OK;
        // n is odd past the first test, so n below 3 means n is one.
        if (!stat.n_low[0]) begin
          res_st_nxt = ST_EVEN;
          state_nxt  = S_DONE;
        end else if (!stat.a_lt_n) begin
          res_st_nxt = ST_NOT_BELOW;
          state_nxt  = S_DONE;
        end else if (stat.n_is_one) begin
          res_st_nxt = ST_SMALL;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.a_zero) begin
          // A remaining n other than one means a common factor.
          res_sym_nxt = stat.n_is_one ? (neg_r ? SYM_NEG : SYM_POS) : SYM_ZERO;
          state_nxt   = S_DONE;
        end else if (!stat.a_low[0]) begin
          op = DP_SHIFT;
          if (stat.n_low == 3'd3 || stat.n_low == 3'd5) begin
            neg_nxt = ~neg_r;
          end
        end else if (stat.a_lt_n) begin
          // Both odd here: quadratic reciprocity on the swap.
          op = DP_SWAP;
          if (stat.a_low == 2'd3 && stat.n_low[1:0] == 2'd3) begin
            neg_nxt = ~neg_r;
          end
        end else begin
          op = DP_SUB;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = res_sym_r;
          out_status_nxt = res_st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      neg_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      neg_r        <= neg_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    res_sym_r    <= res_sym_nxt;
    res_st_r     <= res_st_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_status = out_status_r;

endmodule : jacobi_symbol_unit

`default_nettype wire

// ===== rtl/jsu_datapath.sv =====
// ----------------------------------------------------------------------------
// jsu_datapath
// Operand registers a and n around a single shared subtractor. The
// subtractor's borrow doubles as the a < n comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_datapath (
  input  wire logic                        clk,
  input  wire jsu_pkg::dp_op_t             op_i,
  input  wire logic [jsu_pkg::WIDTH-1:0]   load_a_i,
  input  wire logic [jsu_pkg::WIDTH-1:0]   load_n_i,
  output jsu_pkg::dp_stat_t                stat_o
);
  import jsu_pkg::*;

  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] n_r;
  logic [WIDTH-1:0] a_nxt;
  logic [WIDTH-1:0] n_nxt;
  logic [WIDTH:0]   diff;

  assign diff = {1'b0, a_r} - {1'b0, n_r};

  always_comb begin
    a_nxt = a_r;
    n_nxt = n_r;
    case (op_i)
      DP_HOLD:  ;
      DP_LOAD: begin
        a_nxt = load_a_i;
        n_nxt = load_n_i;
      end
      DP_SHIFT: a_nxt = {1'b0, a_r[WIDTH-1:1]};
      DP_SWAP: begin
        a_nxt = n_r;
        n_nxt = a_r;
      end
      DP_SUB:   a_nxt = diff[WIDTH-1:0];
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    n_r <= n_nxt;
  end

  assign stat_o.a_zero   = (a_r == '0);
  assign stat_o.a_lt_n   = diff[WIDTH];
  assign stat_o.n_is_one = (n_r == WIDTH'(1));
  assign stat_o.a_low    = a_r[1:0];
  assign stat_o.n_low    = n_r[2:0];

endmodule : jsu_datapath

`default_nettype wire

// ===== test/tb_jacobi_symbol_unit.sv =====
// ----------------------------------------------------------------------------
// tb_jacobi_symbol_unit
// Self-checking bench for the Jacobi symbol unit. A directed table covers the
// operand extremes, every rejection code with its priority order, a zero
// operand and a common factor. About 1600 random operand pairs follow, mostly
// legal pairs of mixed magnitude. Both channels idle at random, and the result
// side holds off once for a long stretch. Every result is checked against the
// typed result of its table row or a local model of the reduction loop.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_jacobi_symbol_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned LOOP_CYCLES  = 6 * WIDTH + 4;
  localparam int unsigned HOLD_CYCLES  = 2500;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned IDLE_PCT     = 13;
  localparam logic [FIELD_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    status_t          st;
  } jacobi_res_t;

  typedef struct packed {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] n;
    logic               typed;
    jacobi_res_t        res;
  } dir_row_t;

  localparam int unsigned DIR_N = 23;

  // Rows with typed set carry a result that is plain from the definition;
  // the others are left to the predictor.
  dir_row_t dir_tab [DIR_N] = '{
    '{64'd0, 64'd0, 1'b1, '{SYM_ZERO, ST_EVEN}},
    '{64'd2, 64'd2, 1'b1, '{SYM_ZERO, ST_EVEN}},
    '{64'd1, 64'd1, 1'b1, '{SYM_ZERO, ST_NOT_BELOW}},
    '{64'd0, 64'd1, 1'b1, '{SYM_ZERO, ST_SMALL}},
    '{64'd7, 64'd7, 1'b1, '{SYM_ZERO, ST_NOT_BELOW}},
    '{ALL_ONES, ALL_ONES, 1'b1, '{SYM_ZERO, ST_NOT_BELOW}},
    '{64'd5, ALL_ONES - 64'd1, 1'b1, '{SYM_ZERO, ST_EVEN}},
    '{ALL_ONES, 64'd3, 1'b1, '{SYM_ZERO, ST_NOT_BELOW}},
    '{64'd0, 64'd3, 1'b1, '{SYM_ZERO, ST_OK}},
    '{64'd1, 64'd3, 1'b1, '{SYM_POS, ST_OK}},
    '{64'd2, 64'd3, 1'b0, '{SYM_ZERO, ST_OK}},
    '{64'd3, 64'd9, 1'b1, '{SYM_ZERO, ST_OK}},
    '{64'd21, 64'd35, 1'b1, '{SYM_ZERO, ST_OK}},
    '{64'd0, ALL_ONES, 1'b1, '{SYM_ZERO, ST_OK}},
    '{64'd1, ALL_ONES, 1'b1, '{SYM_POS, ST_OK}},
    '{ALL_ONES - 64'd1, ALL_ONES, 1'b0, '{SYM_ZERO, ST_OK}},
    '{ALL_ONES - 64'd2, ALL_ONES, 1'b0, '{SYM_ZERO, ST_OK}},
    '{64'd2, ALL_ONES, 1'b0, '{SYM_ZERO, ST_OK}},
    '{64'h8000_0000_0000_0000, ALL_ONES, 1'b0, '{SYM_ZERO, ST_OK}},
    '{64'h5555_5555_5555_5555, ALL_ONES, 1'b0, '{SYM_ZERO, ST_OK}},
    '{64'h0AAA_AAAA_AAAA_AAAA, 64'h1FFF_FFFF_FFFF_FFFF, 1'b0, '{SYM_ZERO, ST_OK}},
    '{64'h1FFF_FFFF_FFFF_FFFE, 64'h1FFF_FFFF_FFFF_FFFF, 1'b0, '{SYM_ZERO, ST_OK}},
    '{64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 1'b0, '{SYM_ZERO, ST_OK}}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FIELD_W-1:0]        in_a_value = '0;
  logic [FIELD_W-1:0]        in_n_modulus = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SYM_W-1:0]   out_symbol;
  logic [ST_W-1:0]           out_status;

  // Side information travelling with the payload of the offered transaction.
  logic                      cur_typed = 1'b0;
  jacobi_res_t               cur_res = '0;

  logic                      calm = 1'b0;
  logic                      hold_req = 1'b0;
  logic                      hold_done = 1'b0;
  int unsigned               hold_left = 0;

  jacobi_res_t               symbol_q [$];
  int unsigned               fail_cnt = 0;
  int unsigned               cycle_cnt = 0;
  int unsigned               cnt_pos = 0;
  int unsigned               cnt_neg = 0;
  int unsigned               cnt_zero = 0;
  int unsigned               cnt_rej = 0;

  jacobi_symbol_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_value   (in_a_value),
    .in_n_modulus (in_n_modulus),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_symbol   (out_symbol),
    .out_status   (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic jacobi_res_t predict_symbol(logic [FIELD_W-1:0] a_in,
                                                 logic [FIELD_W-1:0] n_in);
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] n;
    logic [WIDTH-1:0] t;
    logic             neg;
    jacobi_res_t      r;
    a = a_in[WIDTH-1:0];
    n = n_in[WIDTH-1:0];
    neg = 1'b0;
    r.sym = SYM_ZERO;
    r.st = ST_OK;
    if (!n[0]) begin
      r.st = ST_EVEN;
    end else if (a >= n) begin
      r.st = ST_NOT_BELOW;
    end else if (n < 3) begin
      r.st = ST_SMALL;
    end else begin
      while (a != '0) begin
        while (!a[0]) begin
          a = a >> 1;
          if (n[2:0] == 3'd3 || n[2:0] == 3'd5) neg = ~neg;
        end
        t = a;
        a = n;
        n = t;
        if (a[1:0] == 2'b11 && n[1:0] == 2'b11) neg = ~neg;
        a = a % n;
      end
      // A remaining n above one means a and n had a common factor.
      if (n == 1) r.sym = neg ? SYM_NEG : SYM_POS;
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_bits(int unsigned nbits);
    logic [FIELD_W-1:0] v;
    v = {$urandom, $urandom};
    if (nbits < FIELD_W) v &= (64'd1 << nbits) - 64'd1;
    return v;
  endfunction

  // Legal modulus of a random bit length, leaning towards the full width.
  function automatic logic [FIELD_W-1:0] legal_modulus();
    int unsigned        bits;
    logic [FIELD_W-1:0] n;
    bits = ($urandom_range(99) < 30) ? FIELD_W : $urandom_range(2, FIELD_W - 1);
    n = rand_bits(bits) | 64'd1;
    n[bits-1] = 1'b1;
    if (n < 3) n = 64'd3;
    return n;
  endfunction

  function automatic void make_pair(output logic [FIELD_W-1:0] a,
                                    output logic [FIELD_W-1:0] n);
    int unsigned        kind;
    int unsigned        f;
    logic [FIELD_W-1:0] m;
    kind = $urandom_range(99);
    n = legal_modulus();
    a = rand_bits(FIELD_W) % n;
    if (kind >= 70 && kind < 75) begin
      // Both operands share an odd factor.
      m = rand_bits($urandom_range(1, 48)) | 64'd1;
      f = 2 * $urandom_range(1, 50) + 1;
      n = m * f;
      a = (rand_bits(14) * f) % n;
    end else if (kind >= 75 && kind < 80) begin
      case ($urandom_range(4))
        0: a = '0;
        1: a = 64'd1;
        2: a = n - 64'd1;
        3: a = 64'd2;
        default: a = (64'd1 << $urandom_range(0, FIELD_W - 1)) % n;
      endcase
    end else if (kind >= 80 && kind < 86) begin
      n = rand_bits(FIELD_W) & ~64'd1;
      a = rand_bits(FIELD_W);
    end else if (kind >= 86 && kind < 93) begin
      n = rand_bits(FIELD_W) | 64'd1;
      a = n | rand_bits(FIELD_W);
    end else if (kind >= 93 && kind < 97) begin
      n = ($urandom_range(2) == 0) ? 64'd0 : 64'd1;
      a = ($urandom_range(1) == 0) ? 64'd0 : 64'd1;
    end else if (kind >= 97) begin
      n = rand_bits(FIELD_W);
      a = rand_bits(FIELD_W);
    end
  endfunction

  // Offers one transaction and returns at the edge where it is taken.
  // Valid is only lowered when a gap follows, so it never drops and rises
  // again within one time step.
  task automatic offer_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] n,
                            input logic typed, input jacobi_res_t res);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_a_value   <= a;
    in_n_modulus <= n;
    cur_typed    <= typed;
    cur_res      <= res;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Result side: random stalls, one long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : monitor
    jacobi_res_t got;
    jacobi_res_t want;
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1) begin
        symbol_q.push_back(cur_typed ? cur_res : predict_symbol(in_a_value, in_n_modulus));
      end
      if (out_valid === 1'b1 && out_ready) begin
        got.sym = out_symbol;
        got.st  = status_t'(out_status);
        if (symbol_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: symbol %0d status %0d",
                   $time, $signed(got.sym), got.st);
          fail_cnt++;
        end else begin
          want = symbol_q.pop_front();
          if (got.sym !== want.sym) begin
            $display("%0t: symbol mismatch: expected %0d, actual %0d",
                     $time, $signed(want.sym), $signed(got.sym));
            fail_cnt++;
          end
          if (got.st !== want.st) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.st, got.st);
            fail_cnt++;
          end
        end
        if (got.st != ST_OK) cnt_rej++;
        else if (got.sym == SYM_POS) cnt_pos++;
        else if (got.sym == SYM_NEG) cnt_neg++;
        else cnt_zero++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, symbol_q.size());
      $display("tb_jacobi_symbol_unit: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      offer_pair(dir_tab[i].a, dir_tab[i].n, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_req <= 1'b1;
      if (i == 900) calm <= 1'b1;
      if (i == 1100) calm <= 1'b0;
      make_pair(a, n);
      offer_pair(a, n, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // One more edge so that the last accepted transaction is surely queued.
    @(posedge clk);
    while (symbol_q.size() != 0) @(posedge clk);
    repeat (LOOP_CYCLES) @(posedge clk);

    $display("Checked %0d directed and %0d random pairs with idling on both sides",
             DIR_N, RANDOM_ITEMS);
    $display("Results: +1 %0d, -1 %0d, 0 %0d, rejected %0d; one long output hold-off",
             cnt_pos, cnt_neg, cnt_zero, cnt_rej);
    if (fail_cnt == 0) begin
      $display("tb_jacobi_symbol_unit: clean");
    end else begin
      $display("tb_jacobi_symbol_unit: errors");
    end
    $finish;
  end

endmodule : tb_jacobi_symbol_unit

`default_nettype wire
